[rtl/fmp_pkg.sv]
// Shared widths and constants for the curve25519 field multiplier.
package fmp_pkg;

    localparam int unsigned LIMB_W     = 32;
    localparam int unsigned LIMBS      = 8;
    localparam int unsigned OPER_W     = LIMB_W * LIMBS;
    localparam int unsigned PROD_W     = 2 * OPER_W;
    localparam int unsigned RES_W      = OPER_W - 1;
    localparam int unsigned FOLD_W     = OPER_W + 6;
    localparam int unsigned MUL_STAGES = 5;
    localparam int unsigned RED_STAGES = 4;

    localparam logic [OPER_W:0] MODULUS =
        {2'b00, {(OPER_W - 6){1'b1}}, 5'b01101};
    localparam logic [OPER_W:0] MODULUS_X2 = {MODULUS[OPER_W-1:0], 1'b0};
    localparam logic [5:0] FOLD_FACTOR = 6'd38;

    typedef logic [2*LIMB_W-1:0] pp_t;

endpackage

[rtl/fmp_mul.sv]
// Pipelined 256 by 256 bit multiplier built from 32 by 32 bit partial products.
module fmp_mul
    import fmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OPER_W-1:0] in_a,
    input  logic [OPER_W-1:0] in_b,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PROD_W-1:0] out_prod
);

    logic [MUL_STAGES-1:0] vld_reg;
    logic [MUL_STAGES-1:0] rdy;

    logic [OPER_W-1:0] a_reg;
    logic [OPER_W-1:0] b_reg;
    pp_t pp_reg [LIMBS][LIMBS];
    logic [OPER_W+LIMB_W-1:0] row_reg [LIMBS];
    logic [OPER_W+2*LIMB_W-1:0] quad_reg [LIMBS/2];
    logic [PROD_W-1:0] prod_reg;

    always_comb
    begin
        rdy[MUL_STAGES-1] = !vld_reg[MUL_STAGES-1] || out_ready;
        for (int k = MUL_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[MUL_STAGES-1];
    assign out_prod  = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < MUL_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            a_reg <= in_a;
            b_reg <= in_b;
        end
        if (rdy[1])
        begin
            for (int i = 0; i < LIMBS; i++)
            begin
                for (int j = 0; j < LIMBS; j++)
                begin
                    pp_reg[i][j] <= pp_t'(a_reg[i*LIMB_W +: LIMB_W])
                                  * pp_t'(b_reg[j*LIMB_W +: LIMB_W]);
                end
            end
        end
    end

    logic [OPER_W+LIMB_W-1:0] even_sum [LIMBS];
    logic [OPER_W+LIMB_W-1:0] odd_sum [LIMBS];

    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            even_sum[i] = '0;
            odd_sum[i]  = '0;
            for (int j = 0; j < LIMBS; j += 2)
            begin
                even_sum[i][j*LIMB_W +: 2*LIMB_W]     = pp_reg[i][j];
                odd_sum[i][(j+1)*LIMB_W +: 2*LIMB_W]  = pp_reg[i][j+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int i = 0; i < LIMBS; i++)
            begin
                row_reg[i] <= even_sum[i] + odd_sum[i];
            end
        end
        if (rdy[3])
        begin
            for (int k = 0; k < LIMBS / 2; k++)
            begin
                quad_reg[k] <= {{LIMB_W{1'b0}}, row_reg[2*k]}
                             + {row_reg[2*k+1], {LIMB_W{1'b0}}};
            end
        end
        if (rdy[4])
        begin
            prod_reg <= PROD_W'({{(2*LIMB_W){1'b0}}, quad_reg[0]})
                      + PROD_W'({quad_reg[1], {(2*LIMB_W){1'b0}}})
                      + PROD_W'({quad_reg[2], {(4*LIMB_W){1'b0}}})
                      + PROD_W'({quad_reg[3], {(6*LIMB_W){1'b0}}});
        end
    end

endmodule

[rtl/field_multiply_mod_p25519.sv]
// Top level of the pipelined multiplier modulo 2^255 - 19.
// Usage: operands arrive on the s_ channel, one transaction per product, with
// tdata carrying a_word0..a_word3 then b_word0..b_word3, 64 bits each.
// The fully reduced product leaves on the m_ channel as res_word0..res_word3.
// The block accepts a new transaction in every cycle while the output flows.
// There are nine register stages: five stages form the 512-bit product from
// 64 parallel 32 by 32 bit multipliers and an adder tree, three stages fold
// the upper half back using 2^256 = 38 mod p, and one stage subtracts p or
// 2p as needed.
// Each stage holds a valid bit, so bubbles are squeezed out when the
// receiver stalls, and no transaction is lost or repeated.
// Reset clears all valid bits; no data registers are cleared.
// While m_tready is low, the pipeline keeps filling until every stage holds
// a transaction, and then s_tready drops.
module field_multiply_mod_p25519
    import fmp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // a_word0, a_word1, a_word2, a_word3, b_word0, b_word1, b_word2, b_word3.
    input  logic [2*OPER_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // res_word0, res_word1, res_word2, res_word3 (63 bits), one zero pad bit.
    output logic [OPER_W-1:0]   m_tdata
);

    logic              mul_valid;
    logic              mul_ready;
    logic [PROD_W-1:0] mul_prod;

    fmp_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_a      (s_tdata[OPER_W-1:0]),
        .in_b      (s_tdata[2*OPER_W-1:OPER_W]),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_prod  (mul_prod)
    );

    logic [RED_STAGES-1:0] vld_reg;
    logic [RED_STAGES-1:0] rdy;

    logic [FOLD_W-1:0] fold1_reg;
    logic [OPER_W:0]   fold2_reg;
    logic [OPER_W-1:0] fold3_reg;
    logic [RES_W-1:0]  res_reg;

    always_comb
    begin
        rdy[RED_STAGES-1] = !vld_reg[RED_STAGES-1] || m_tready;
        for (int k = RED_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign mul_ready = rdy[0];
    assign m_tvalid  = vld_reg[RED_STAGES-1];
    assign m_tdata   = {1'b0, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= mul_valid;
            end
            for (int k = 1; k < RED_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    logic [OPER_W-1:0] hi;
    logic [OPER_W:0]   diff1;
    logic [OPER_W:0]   diff2;

    assign hi    = mul_prod[PROD_W-1:OPER_W];
    assign diff1 = {1'b0, fold3_reg} - MODULUS;
    assign diff2 = {1'b0, fold3_reg} - MODULUS_X2;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            fold1_reg <= FOLD_W'(mul_prod[OPER_W-1:0])
                       + FOLD_W'({hi, 5'b0})
                       + FOLD_W'({hi, 2'b0})
                       + FOLD_W'({hi, 1'b0});
        end
        if (rdy[1])
        begin
            fold2_reg <= (OPER_W+1)'(fold1_reg[OPER_W-1:0])
                       + (OPER_W+1)'(12'(fold1_reg[FOLD_W-1:OPER_W]) * 12'(FOLD_FACTOR));
        end
        if (rdy[2])
        begin
            fold3_reg <= fold2_reg[OPER_W-1:0]
                       + (fold2_reg[OPER_W] ? OPER_W'(FOLD_FACTOR) : '0);
        end
        if (rdy[3])
        begin
            priority if (!diff2[OPER_W])
            begin
                res_reg <= diff2[RES_W-1:0];
            end
            else if (!diff1[OPER_W])
            begin
                res_reg <= diff1[RES_W-1:0];
            end
            else
            begin
                res_reg <= fold3_reg[RES_W-1:0];
            end
        end
    end

endmodule

[bench/field_multiply_mod_p25519_tb.sv]
// Testbench for the curve25519 field multiplier with random and corner operands.
`timescale 1ns / 1ps

module field_multiply_mod_p25519_tb;

    localparam logic [255:0] P25519 = {1'b0, {250{1'b1}}, 5'b01101};

    class product_scoreboard;
        logic [254:0] pending_products[$];
        int unsigned  mismatches;

        function logic [254:0] mul_mod(logic [255:0] a, logic [255:0] b);
            logic [511:0] wide;
            wide = a * b;
            wide = wide % {256'd0, P25519};
            return wide[254:0];
        endfunction

        function void note_operands(logic [511:0] operands);
            pending_products.push_back(mul_mod(operands[255:0], operands[511:256]));
        endfunction

        function void check_product(logic [255:0] actual);
            logic [254:0] expected;
            logic [255:0] exp_full;
            if (pending_products.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected product transaction %h", actual);
                return;
            end
            expected = pending_products.pop_front();
            exp_full = {1'b0, expected};
            for (int w = 0; w < 4; w++)
            begin
                if (actual[64*w +: 64] !== exp_full[64*w +: 64])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("res_word%0d mismatch: expected %h actual %h", w,
                                 exp_full[64*w +: 64], actual[64*w +: 64]);
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [511:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;

    product_scoreboard board;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic [255:0] corner_vals[8];

    field_multiply_mod_p25519 u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [255:0] rand_operand();
        logic [255:0] v;
        for (int i = 0; i < 8; i++)
            v[32*i +: 32] = $urandom;
        case ($urandom_range(0, 7))
            0: v = P25519 + $urandom_range(0, 40);
            1: v = P25519 - $urandom_range(0, 40);
            2: v[255:32] = {224{1'b1}};
            3: v[255:64] = '0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_operands(logic [255:0] a, logic [255:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_operands({b, a});
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_product(m_tdata);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        board = new();
        corner_vals = '{256'd0, 256'd1, 256'd2, P25519 - 1, P25519, P25519 + 1,
                        {256{1'b1}}, {1'b1, 255'd0}};
        send_idle_pct = 33;
        recv_idle_pct = 75;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 8; i++)
            for (int j = i; j < 8; j += 3)
                send_operands(corner_vals[i], corner_vals[j]);
        for (int n = 0; n < 1850; n++)
        begin
            if (n == 620)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 33;
            end
            if (n == 1240)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_operands(rand_operand(), rand_operand());
        end
        s_tvalid <= 1'b0;
        while (board.pending_products.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
